// File: src/cluster_pattern_noise_counter_macros.svh
// Assertion macros used by the cluster noise counter core RTL.
`ifndef CLUSTER_PATTERN_NOISE_COUNTER_MACROS_SVH
`define CLUSTER_PATTERN_NOISE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPNC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cpnc_pkg.sv
// Shared types, codes and helpers of the cluster noise counter.
package cpnc_pkg;

	localparam int CHIPS_DEF      = 2;
	localparam int ROWS_DEF       = 512;
	localparam int COLS_DEF       = 1024;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [5:0]  MAX_SPAN        = 6'd32;
	localparam logic [23:0] MIN_STROBES_RST = 24'd1000;

	localparam logic [1:0] OP_HEADER  = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_FRAME   = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_NO_CLUSTER = 2'd1;
	localparam logic [1:0] STATUS_OFF_MAP    = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SINGLE,
		S_BITS,
		S_FIN,
		S_HOLD
	} state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       chip_id;
		logic [8:0] row;
		logic [9:0] col;
		logic [5:0] row_span;
		logic [5:0] col_span;
		logic       has_pattern_id;
		logic [7:0] pattern_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] pixel_count;
		logic [1:0]  status;
	} result_t;

	function automatic logic [5:0] clamp_span(input logic [5:0] s);
		logic [5:0] r;
		if (s == 6'd0) begin
			r = 6'd1;
		end else if (s > MAX_SPAN) begin
			r = MAX_SPAN;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

// File: src/cpnc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cpnc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/cpnc_core.sv
// Cluster sequencer with read-modify-write of the pixel counter memory.
`include "cluster_pattern_noise_counter_macros.svh"

module cpnc_core #(
	parameter int CHIPS      = 2,
	parameter int ROWS       = 512,
	parameter int COLS       = 1024,
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  cpnc_pkg::item_t   item,
	output logic              ready,
	output logic              res_valid,
	output cpnc_pkg::result_t res,
	input  logic              res_take
);
	import cpnc_pkg::*;

	// Chip index is one bit wide, so at most two chips are ever addressed.
	localparam int USED_CHIPS = (CHIPS < 2) ? CHIPS : 2;
	localparam int DEPTH      = USED_CHIPS * ROWS * COLS;
	localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW         = AW + 12;
	localparam int CW         = COUNT_BITS;

	state_t state_q, state_d;

	logic [AW-1:0] clear_addr_q;
	logic          clear_last;

	// Open cluster.
	logic       cluster_open_q;
	logic       open_chip_q;
	logic [8:0] open_row_q;
	logic [9:0] open_col_q;
	logic [5:0] open_rspan_q;
	logic [5:0] open_cspan_q;
	logic [4:0] row_off_q;
	logic [4:0] col_off_q;
	logic [2:0] bit_idx_q;

	// Current item.
	logic [1:0] op_q;
	logic       chip_q;
	logic [8:0] row_q;
	logic [9:0] col_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic [15:0] count_q;

	// Write-back stage.
	logic          wr_pending_s1;
	logic          rd_cnt_s1;
	logic [AW-1:0] addr_s1;

	logic [5:0] hdr_rspan;
	logic [5:0] hdr_cspan;
	logic       hdr_single;

	logic          sel_chip;
	logic [9:0]    sel_row;
	logic [10:0]   sel_col;
	logic          in_map;
	logic [XW-1:0] lin;
	logic [AW-1:0] pix_addr;

	logic       cur_bit;
	logic [5:0] col_next;
	logic [5:0] row_next;
	logic       col_wrap;
	logic       row_wrap;

	logic          rd_en;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic [CW-1:0] mem_rdata;
	logic [CW-1:0] cnt_inc;
	logic [CW+15:0] cnt_ext;
	logic [15:0]   count_now;

	assign clear_last = (clear_addr_q == AW'(DEPTH - 1));

	assign hdr_rspan  = clamp_span(item.row_span);
	assign hdr_cspan  = clamp_span(item.col_span);
	assign hdr_single = !item.has_pattern_id && (hdr_rspan == 6'd1) && (hdr_cspan == 6'd1);

	// Pixel under work: bitmap position in BITS, otherwise the stored item.
	always_comb begin
		if (state_q == S_BITS) begin
			sel_chip = open_chip_q;
			sel_row  = {1'b0, open_row_q} + {5'd0, row_off_q};
			sel_col  = {1'b0, open_col_q} + {6'd0, col_off_q};
		end else begin
			sel_chip = chip_q;
			sel_row  = {1'b0, row_q};
			sel_col  = {1'b0, col_q};
		end
		in_map   = (32'(sel_chip) < 32'(CHIPS)) && (32'(sel_row) < 32'(ROWS)) &&
			(32'(sel_col) < 32'(COLS));
		lin      = (XW'(sel_chip ? ROWS : 0) + XW'(sel_row)) * XW'(COLS) + XW'(sel_col);
		pix_addr = lin[AW-1:0];
	end

	always_comb begin
		cur_bit  = byte_q[3'd7 - bit_idx_q];
		col_next = {1'b0, col_off_q} + 6'd1;
		row_next = {1'b0, row_off_q} + 6'd1;
		col_wrap = (col_next >= open_cspan_q);
		row_wrap = col_wrap && (row_next >= open_rspan_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					case (item.opcode)
						OP_HEADER:  state_d = hdr_single ? S_SINGLE : S_FIN;
						OP_PATTERN: state_d = cluster_open_q ? S_BITS : S_FIN;
						OP_FRAME:   state_d = S_FIN;
						default:    state_d = S_SINGLE;
					endcase
				end
			end
			S_SINGLE: state_d = S_FIN;
			S_BITS: begin
				if (row_wrap || (bit_idx_q == 3'd7)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = res_take ? S_IDLE : S_HOLD;
			S_HOLD: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// State machine outputs.
	always_comb begin
		ready     = (state_q == S_IDLE);
		res_valid = (state_q == S_FIN) || (state_q == S_HOLD);
		case (state_q)
			S_SINGLE: rd_en = in_map;
			S_BITS:   rd_en = cur_bit && in_map;
			default:  rd_en = 1'b0;
		endcase
	end

	// Memory write port: the clearing pass, or the write-back of a read from the previous cycle.
	always_comb begin
		cnt_inc = (mem_rdata == {CW{1'b1}}) ? mem_rdata : mem_rdata + CW'(1);
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clear_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = wr_pending_s1;
			mem_waddr = addr_s1;
			mem_wdata = cnt_inc;
		end
		cnt_ext   = {16'd0, mem_rdata};
		count_now = rd_cnt_s1 ? cnt_ext[15:0] : 16'd0;
		res.pixel_count = (state_q == S_FIN) ? count_now : count_q;
		res.status      = status_q;
	end

	cpnc_ram #(
		.WIDTH(CW),
		.DEPTH(DEPTH)
	) u_counts (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (rd_en),
		.raddr(pix_addr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			clear_addr_q   <= '0;
			cluster_open_q <= 1'b0;
			open_chip_q    <= 1'b0;
			open_row_q     <= '0;
			open_col_q     <= '0;
			open_rspan_q   <= 6'd1;
			open_cspan_q   <= 6'd1;
			row_off_q      <= '0;
			col_off_q      <= '0;
			bit_idx_q      <= '0;
			status_q       <= STATUS_OK;
			wr_pending_s1  <= 1'b0;
			rd_cnt_s1      <= 1'b0;
		end else begin
			state_q       <= state_d;
			wr_pending_s1 <= rd_en && !((state_q == S_SINGLE) && (op_q == OP_READ));
			rd_cnt_s1     <= rd_en && (state_q == S_SINGLE) && (op_q == OP_READ);
			if (state_q == S_CLEAR) begin
				clear_addr_q <= clear_addr_q + AW'(1);
			end
			if (state_q == S_IDLE && item_valid) begin
				bit_idx_q <= '0;
				if (item.opcode == OP_PATTERN && !cluster_open_q) begin
					status_q <= STATUS_NO_CLUSTER;
				end else begin
					status_q <= STATUS_OK;
				end
				if (item.opcode == OP_HEADER) begin
					// Dropped and 1x1 clusters leave nothing open.
					cluster_open_q <= !item.has_pattern_id && !hdr_single;
					row_off_q      <= '0;
					col_off_q      <= '0;
					if (!item.has_pattern_id) begin
						open_chip_q    <= item.chip_id;
						open_row_q     <= item.row;
						open_col_q     <= item.col;
						open_rspan_q   <= hdr_rspan;
						open_cspan_q   <= hdr_cspan;
					end
				end
			end
			if ((state_q == S_SINGLE) && !in_map) begin
				status_q <= STATUS_OFF_MAP;
			end
			if (state_q == S_BITS) begin
				if (cur_bit && !in_map) begin
					status_q <= STATUS_OFF_MAP;
				end
				bit_idx_q <= bit_idx_q + 3'd1;
				if (col_wrap) begin
					col_off_q <= '0;
					if (row_wrap) begin
						row_off_q      <= '0;
						cluster_open_q <= 1'b0;
					end else begin
						row_off_q <= row_next[4:0];
					end
				end else begin
					col_off_q <= col_next[4:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= pix_addr;
		if (state_q == S_IDLE && item_valid) begin
			op_q   <= item.opcode;
			chip_q <= item.chip_id;
			row_q  <= item.row;
			col_q  <= item.col;
			byte_q <= item.pattern_byte;
		end
		if (state_q == S_FIN) begin
			count_q <= count_now;
		end
	end

	`CPNC_ASSERT_IMPL(a_accept_idle, clk, arst_n, item_valid, state_q == S_IDLE,
		"item transfer outside idle")
	`CPNC_ASSERT_IMPL(a_wb_state, clk, arst_n, wr_pending_s1,
		(state_q == S_BITS) || (state_q == S_FIN), "write-back outside bit or finish state")
	`CPNC_ASSERT_IMPL(a_no_overlap, clk, arst_n, rd_en && wr_pending_s1,
		pix_addr != addr_s1, "read and write-back hit the same counter")
	`CPNC_ASSERT_IMPL(a_bits_open, clk, arst_n, state_q == S_BITS, cluster_open_q,
		"bitmap walk without an open cluster")

endmodule

// File: src/cluster_pattern_noise_counter.sv
// Pixel noise histogram: per-pixel saturating counters in one RAM, strobe total, result register.
// Sequencer path: frame end, dropped or wide header and stray byte go from IDLE straight to FIN;
// a 1x1 header or a read passes through SINGLE; a pattern byte walks BITS (one bit a cycle) first.
// Items are taken one at a time: the next item can be taken from the cycle after the result leaves the sequencer.
// Reset: a clearing pass zeroes min(CHIPS,2)*ROWS*COLS counters, one per cycle.
module cluster_pattern_noise_counter #(
	parameter int CHIPS      = cpnc_pkg::CHIPS_DEF,
	parameter int ROWS       = cpnc_pkg::ROWS_DEF,
	parameter int COLS       = cpnc_pkg::COLS_DEF,
	parameter int COUNT_BITS = cpnc_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic        chip_id,
	input  logic [8:0]  row,
	input  logic [9:0]  col,
	input  logic [5:0]  row_span,
	input  logic [5:0]  col_span,
	input  logic        has_pattern_id,
	input  logic [7:0]  pattern_byte,
	input  logic [9:0]  frame_strobes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_count,
	output logic        enough_data,
	output logic [1:0]  status
);
	import cpnc_pkg::*;

	logic [23:0] min_strobes_q;
	logic [31:0] strobe_total_q;
	logic [32:0] strobe_sum;
	logic        in_xfer;
	item_t       item;
	logic        core_ready;
	logic        res_valid;
	result_t     res;
	logic        res_take;
	logic        out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = core_ready;
	assign in_xfer   = in_valid && in_ready;
	assign res_take  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign strobe_sum = {1'b0, strobe_total_q} + {23'd0, frame_strobes};

	always_comb begin
		item.opcode         = opcode;
		item.chip_id        = chip_id;
		item.row            = row;
		item.col            = col;
		item.row_span       = row_span;
		item.col_span       = col_span;
		item.has_pattern_id = has_pattern_id;
		item.pattern_byte   = pattern_byte;
	end

	cpnc_core #(
		.CHIPS     (CHIPS),
		.ROWS      (ROWS),
		.COLS      (COLS),
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(in_xfer),
		.item      (item),
		.ready     (core_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_strobes_q  <= MIN_STROBES_RST;
			strobe_total_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				min_strobes_q <= cfg_data;
			end
			// The total sticks at its maximum instead of wrapping.
			if (in_xfer && opcode == OP_FRAME) begin
				strobe_total_q <= strobe_sum[32] ? 32'hFFFF_FFFF : strobe_sum[31:0];
			end
			if (res_valid && res_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			pixel_count <= res.pixel_count;
			status      <= res.status;
			enough_data <= (strobe_total_q > {8'd0, min_strobes_q});
		end
	end

endmodule
